[sv/tco_pkg.sv]
// Shared types and constant tables for the triangle versus unit-cube overlap core.
package tco_pkg;

    localparam int EPS_BITS = 8;
    localparam logic [EPS_BITS-1:0] EPS_RESET = 8'd1;

    localparam int NUM_VERT = 3;
    localparam int NUM_AXIS = 3;
    localparam int NUM_DIAG = 4;
    localparam int NUM_FACE = 6;

    typedef struct packed {
        logic [7:0]  corner;
        logic [11:0] bevel;
        logic [5:0]  face;
    } outcode_t;

    // vertex pairs of the three triangle edges (segment tests and bevel axis pairs)
    localparam int SEG_P [3] = '{0, 0, 1};
    localparam int SEG_Q [3] = '{1, 2, 2};

    // edges used by the point-in-triangle test
    localparam int EDGE_I [3] = '{0, 1, 2};
    localparam int EDGE_J [3] = '{1, 2, 0};

    // the two other axes of each axis, in cross-product order
    localparam int AX_NEXT [3][2] = '{'{1, 2}, '{2, 0}, '{0, 1}};

    // negated components of each cube diagonal, bit k for axis k
    localparam logic [2:0] DIAG_NEG [4] = '{3'b000, 3'b100, 3'b010, 3'b110};

endpackage

[sv/triangle_cube_overlap_core.sv]
// Pipelined triangle versus unit-cube overlap test, top level.
//
//  channel | ports                      | direction | word
//  --------+----------------------------+-----------+---------------------------------
//  input   | s_valid s_ready s_v*_*     | in        | nine signed vertex coordinates
//  result  | m_valid m_ready m_overlaps | out       | one overlap flag
//  config  | cfg_we cfg_wdata           | in        | epsilon_lsb, no handshake
//
//  One word enters per cycle unless a held result stalls the pipe; each word passes stages 1 to 9 in order.
//  The depth is set by the chain of four registered multiplier ranks: normal,
//  plane offset, diagonal scaling and edge cross products.
//  All stages advance together; a held result stalls the whole pipe and s_ready drops.
//  Reset clears valid bits and sets epsilon_lsb to one; no word is lost or repeated.
module triangle_cube_overlap_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [COORD_BITS-1:0]    s_v0_x,
    input  logic signed [COORD_BITS-1:0]    s_v0_y,
    input  logic signed [COORD_BITS-1:0]    s_v0_z,
    input  logic signed [COORD_BITS-1:0]    s_v1_x,
    input  logic signed [COORD_BITS-1:0]    s_v1_y,
    input  logic signed [COORD_BITS-1:0]    s_v1_z,
    input  logic signed [COORD_BITS-1:0]    s_v2_x,
    input  logic signed [COORD_BITS-1:0]    s_v2_y,
    input  logic signed [COORD_BITS-1:0]    s_v2_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_overlaps,
    input  logic                            cfg_we,
    input  logic [tco_pkg::EPS_BITS-1:0]    cfg_wdata
);
    import tco_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int FB   = FRAC_BITS;
    localparam int SW   = ((CW > FB) ? CW : FB) + 4;
    localparam int DW   = CW + 1;
    localparam int EPW  = SW + DW;
    localparam int ENW  = EPW + 1;
    localparam int ECW  = ((ENW > DW + FB) ? ENW : DW + FB) + 1;
    localparam int NPW  = 2 * DW;
    localparam int NW   = NPW + 1;
    localparam int DNW  = NW + 2;
    localparam int DPW  = NW + CW;
    localparam int DDW  = DPW + 2;
    localparam int DCW  = ((DNW > EPS_BITS + 1 + FB) ? DNW : EPS_BITS + 1 + FB) + 1;
    localparam int SCW  = ((DDW + 1 > DNW + FB) ? DDW + 1 : DNW + FB) + 1;
    localparam int TDW  = CW + DNW;
    localparam int BCW  = ((TDW > DDW) ? TDW : DDW) + 1;
    localparam int WVW  = BCW;
    localparam int CPW  = DW + WVW;
    localparam int CRW  = CPW + 1;
    localparam int EDW  = EPS_BITS + 1 + DNW;
    localparam int THW  = EDW + FB;
    localparam int CMW  = ((CRW > THW) ? CRW : THW) + 1;

    localparam logic signed [SW-1:0] HALF = SW'(1) << (FB - 1);
    localparam logic signed [SW-1:0] ONE  = SW'(1) << FB;
    localparam logic signed [SW-1:0] LIM3 = SW'(3) << (FB - 1);

    logic adv;
    logic [EPS_BITS-1:0] eps_reg;

    // stage 1
    logic vld1_reg;
    logic signed [CW-1:0] t1_reg [3][3];

    // stage 2
    logic vld2_reg;
    outcode_t             oc2_next [3], oc2_reg [3];
    logic signed [NPW-1:0] np2_next [3][2], np2_reg [3][2];
    logic signed [DW-1:0] dl2_next [3][3], dl2_reg [3][3];
    logic signed [EPW-1:0] ep1_next [3][6][2], ep1_reg [3][6][2];
    logic signed [EPW-1:0] ep2_next [3][6][2], ep2_reg [3][6][2];
    logic signed [CW-1:0] t2_reg [3][3];

    // stage 3
    logic vld3_reg;
    logic signed [NW-1:0] n3_next [3], n3_reg [3];
    logic signed [CW-1:0] mx3_next [3], mx3_reg [3], mn3_next [3], mn3_reg [3];
    logic done3_next, done3_reg, hit3_next, hit3_reg;
    logic signed [CW-1:0] t3_reg [3][3];

    // stage 4
    logic vld4_reg;
    logic signed [DPW-1:0] dp4_next [3], dp4_reg [3];
    logic signed [DNW-1:0] den4_next [4], den4_reg [4];
    logic signed [CW-1:0] mx4_reg [3], mn4_reg [3];
    logic done4_reg, hit4_reg;
    logic signed [CW-1:0] t4_reg [3][3];

    // stage 5
    logic vld5_reg;
    logic signed [DNW-1:0] den5_next [4], den5_reg [4];
    logic signed [DDW-1:0] dd5_next [4], dd5_reg [4];
    logic [3:0] use5_next, use5_reg;
    logic signed [CW-1:0] mx5_reg [3], mn5_reg [3];
    logic done5_reg, hit5_reg;
    logic signed [CW-1:0] t5_reg [3][3];

    // stage 6
    logic vld6_reg;
    logic signed [TDW-1:0] td6_next [4][3][3], td6_reg [4][3][3];
    logic signed [TDW-1:0] bmx6_next [4][3], bmx6_reg [4][3];
    logic signed [TDW-1:0] bmn6_next [4][3], bmn6_reg [4][3];
    logic signed [EDW-1:0] ed6_next [4], ed6_reg [4];
    logic signed [DW-1:0] av6_next [3][3], av6_reg [3][3];
    logic signed [DDW-1:0] dd6_reg [4];
    logic [3:0] use6_reg;
    logic done6_reg, hit6_reg;

    // stage 7
    logic vld7_reg;
    logic signed [WVW-1:0] wv7_next [4][3][3], wv7_reg [4][3][3];
    logic signed [THW-1:0] thr7_next [4], thr7_reg [4];
    logic [3:0] ok7_next, ok7_reg;
    logic signed [DW-1:0] av7_reg [3][3];
    logic done7_reg, hit7_reg;

    // stage 8
    logic vld8_reg;
    logic signed [CPW-1:0] cp8_next [4][3][3][2], cp8_reg [4][3][3][2];
    logic signed [THW-1:0] thr8_reg [4];
    logic [3:0] ok8_reg;
    logic done8_reg, hit8_reg;

    // stage 9 (result register)
    logic vld9_reg;
    logic res9_next, res9_reg;

    assign adv        = !vld9_reg || m_ready;
    assign s_ready    = adv;
    assign m_valid    = vld9_reg;
    assign m_overlaps = res9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
            vld9_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            vld7_reg <= vld6_reg;
            vld8_reg <= vld7_reg;
            vld9_reg <= vld8_reg;
        end
    end

    // stage 2: outcodes, edge deltas, first multiplier rank
    always_comb begin
        logic signed [SW-1:0] sa, sb, sc, pl, pm;
        int p, q, a, j;
        for (int v = 0; v < 3; v++) begin
            oc2_next[v] = '0;
            for (int k = 0; k < 3; k++) begin
                oc2_next[v].face[2*k]     = SW'(t1_reg[v][k]) > HALF;
                oc2_next[v].face[2*k + 1] = SW'(t1_reg[v][k]) < -HALF;
            end
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 4; k++) begin
                    sa = ((k & 2) != 0) ? -SW'(t1_reg[v][SEG_P[e]]) : SW'(t1_reg[v][SEG_P[e]]);
                    sb = ((k & 1) != 0) ? -SW'(t1_reg[v][SEG_Q[e]]) : SW'(t1_reg[v][SEG_Q[e]]);
                    oc2_next[v].bevel[e*4 + k] = (sa + sb) > ONE;
                end
            end
            for (int k = 0; k < 8; k++) begin
                sa = ((k & 4) != 0) ? -SW'(t1_reg[v][0]) : SW'(t1_reg[v][0]);
                sb = ((k & 2) != 0) ? -SW'(t1_reg[v][1]) : SW'(t1_reg[v][1]);
                sc = ((k & 1) != 0) ? -SW'(t1_reg[v][2]) : SW'(t1_reg[v][2]);
                oc2_next[v].corner[k] = (sa + sb + sc) > LIM3;
            end
        end
        for (int k = 0; k < 3; k++) begin
            np2_next[k][0] = NPW'(DW'(t1_reg[0][AX_NEXT[k][0]]) - DW'(t1_reg[1][AX_NEXT[k][0]]))
                           * NPW'(DW'(t1_reg[0][AX_NEXT[k][1]]) - DW'(t1_reg[2][AX_NEXT[k][1]]));
            np2_next[k][1] = NPW'(DW'(t1_reg[0][AX_NEXT[k][1]]) - DW'(t1_reg[1][AX_NEXT[k][1]]))
                           * NPW'(DW'(t1_reg[0][AX_NEXT[k][0]]) - DW'(t1_reg[2][AX_NEXT[k][0]]));
        end
        for (int s = 0; s < 3; s++) begin
            p = SEG_P[s];
            q = SEG_Q[s];
            for (int k = 0; k < 3; k++) begin
                dl2_next[s][k] = DW'(t1_reg[q][k]) - DW'(t1_reg[p][k]);
            end
            for (int f = 0; f < NUM_FACE; f++) begin
                a  = f >> 1;
                pl = ((f & 1) != 0) ? -HALF : HALF;
                pm = pl - SW'(t1_reg[p][a]);
                for (int m = 0; m < 2; m++) begin
                    j = AX_NEXT[a][m];
                    ep1_next[s][f][m] = EPW'(t1_reg[p][j]) * EPW'(dl2_next[s][a]);
                    ep2_next[s][f][m] = EPW'(pm) * EPW'(DW'(t1_reg[q][j]) - DW'(t1_reg[p][j]));
                end
            end
        end
    end

    // stage 3: normal, segment crossings, early decision
    always_comb begin
        logic signed [ECW-1:0] num, lim;
        logic signed [DW-1:0] d, absd;
        logic [5:0] diff;
        logic seg_ok, ok, in_cube, reject, edge_any;
        edge_any = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n3_next[k] = NW'(np2_reg[k][0]) - NW'(np2_reg[k][1]);
        end
        for (int s = 0; s < 3; s++) begin
            seg_ok = (oc2_reg[SEG_P[s]] & oc2_reg[SEG_Q[s]]) == '0;
            diff   = oc2_reg[SEG_P[s]].face | oc2_reg[SEG_Q[s]].face;
            for (int f = 0; f < NUM_FACE; f++) begin
                d    = dl2_reg[s][f >> 1];
                absd = (d < 0) ? -d : d;
                lim  = ECW'(absd) << (FB - 1);
                ok   = diff[f] && (d != '0) && seg_ok;
                for (int m = 0; m < 2; m++) begin
                    num = ECW'(ENW'(ep1_reg[s][f][m]) + ENW'(ep2_reg[s][f][m]));
                    if (num > lim || num < -lim) begin
                        ok = 1'b0;
                    end
                end
                edge_any = edge_any | ok;
            end
        end
        in_cube = (oc2_reg[0].face == '0) || (oc2_reg[1].face == '0) || (oc2_reg[2].face == '0);
        reject = (oc2_reg[0] & oc2_reg[1] & oc2_reg[2]) != '0;
        done3_next = in_cube || reject || edge_any;
        hit3_next  = in_cube || (!reject && edge_any);
        for (int k = 0; k < 3; k++) begin
            mx3_next[k] = t2_reg[0][k];
            mn3_next[k] = t2_reg[0][k];
            for (int v = 1; v < 3; v++) begin
                if (t2_reg[v][k] > mx3_next[k]) begin
                    mx3_next[k] = t2_reg[v][k];
                end
                if (t2_reg[v][k] < mn3_next[k]) begin
                    mn3_next[k] = t2_reg[v][k];
                end
            end
        end
    end

    // stage 4: plane offset products, diagonal denominators
    always_comb begin
        logic signed [DNW-1:0] acc;
        for (int k = 0; k < 3; k++) begin
            dp4_next[k] = DPW'(n3_reg[k]) * DPW'(t3_reg[0][k]);
        end
        for (int g = 0; g < NUM_DIAG; g++) begin
            acc = DNW'(n3_reg[0]);
            acc = DIAG_NEG[g][1] ? acc - DNW'(n3_reg[1]) : acc + DNW'(n3_reg[1]);
            acc = DIAG_NEG[g][2] ? acc - DNW'(n3_reg[2]) : acc + DNW'(n3_reg[2]);
            den4_next[g] = acc;
        end
    end

    // stage 5: normalize denominators, drop parallel and far diagonals
    always_comb begin
        logic signed [DDW-1:0] dsum, dabs;
        logic signed [DCW-1:0] dene, es;
        logic signed [DNW-1:0] den;
        logic good, far;
        dsum = DDW'(dp4_reg[0]) + DDW'(dp4_reg[1]) + DDW'(dp4_reg[2]);
        dabs = (dsum < 0) ? -dsum : dsum;
        es   = DCW'(signed'({1'b0, eps_reg})) << FB;
        for (int g = 0; g < NUM_DIAG; g++) begin
            den  = den4_reg[g];
            dene = DCW'(den);
            good = (den != '0) && (dene > es || dene < -es);
            den5_next[g] = (den < 0) ? -den : den;
            dd5_next[g]  = (den < 0) ? -dsum : dsum;
            far  = (SCW'(dabs) << 1) > (SCW'(den5_next[g]) << FB);
            use5_next[g] = good && !far;
        end
    end

    // stage 6: scale vertices and bounds by the denominators
    always_comb begin
        for (int g = 0; g < NUM_DIAG; g++) begin
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    td6_next[g][v][k] = TDW'(t5_reg[v][k]) * TDW'(den5_reg[g]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                bmx6_next[g][k] = TDW'(mx5_reg[k]) * TDW'(den5_reg[g]);
                bmn6_next[g][k] = TDW'(mn5_reg[k]) * TDW'(den5_reg[g]);
            end
            ed6_next[g] = EDW'(signed'({1'b0, eps_reg})) * EDW'(den5_reg[g]);
        end
        for (int e = 0; e < 3; e++) begin
            for (int k = 0; k < 3; k++) begin
                av6_next[e][k] = DW'(t5_reg[EDGE_I[e]][k]) - DW'(t5_reg[EDGE_J[e]][k]);
            end
        end
    end

    // stage 7: bounding box check, edge-to-point vectors, thresholds
    always_comb begin
        logic signed [DDW-1:0] pk [3];
        logic box;
        for (int g = 0; g < NUM_DIAG; g++) begin
            box = 1'b1;
            for (int k = 0; k < 3; k++) begin
                pk[k] = DIAG_NEG[g][k] ? -dd6_reg[g] : dd6_reg[g];
                if (BCW'(pk[k]) > BCW'(bmx6_reg[g][k]) || BCW'(pk[k]) < BCW'(bmn6_reg[g][k]))
                begin
                    box = 1'b0;
                end
            end
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    wv7_next[g][e][k] = WVW'(td6_reg[g][EDGE_I[e]][k]) - WVW'(pk[k]);
                end
            end
            thr7_next[g] = THW'(ed6_reg[g]) << FB;
            ok7_next[g]  = use6_reg[g] && box;
        end
    end

    // stage 8: cross product terms
    always_comb begin
        for (int g = 0; g < NUM_DIAG; g++) begin
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    cp8_next[g][e][k][0] = CPW'(av7_reg[e][AX_NEXT[k][0]])
                                         * CPW'(wv7_reg[g][e][AX_NEXT[k][1]]);
                    cp8_next[g][e][k][1] = CPW'(av7_reg[e][AX_NEXT[k][1]])
                                         * CPW'(wv7_reg[g][e][AX_NEXT[k][0]]);
                end
            end
        end
    end

    // stage 9: sign masks and final decision
    always_comb begin
        logic signed [CMW-1:0] cr, thr;
        logic [2:0] all_below, all_above;
        logic [3:0] hit;
        for (int g = 0; g < NUM_DIAG; g++) begin
            thr       = CMW'(thr8_reg[g]);
            all_below = '1;
            all_above = '1;
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    cr = CMW'(CRW'(cp8_reg[g][e][k][0]) - CRW'(cp8_reg[g][e][k][1]));
                    all_below[k] = all_below[k] & (cr < thr);
                    all_above[k] = all_above[k] & (cr > -thr);
                end
            end
            hit[g] = ok8_reg[g] && ((all_below != '0) || (all_above != '0));
        end
        res9_next = done8_reg ? hit8_reg : (hit != '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg[0][0] <= s_v0_x;
            t1_reg[0][1] <= s_v0_y;
            t1_reg[0][2] <= s_v0_z;
            t1_reg[1][0] <= s_v1_x;
            t1_reg[1][1] <= s_v1_y;
            t1_reg[1][2] <= s_v1_z;
            t1_reg[2][0] <= s_v2_x;
            t1_reg[2][1] <= s_v2_y;
            t1_reg[2][2] <= s_v2_z;

            oc2_reg  <= oc2_next;
            np2_reg  <= np2_next;
            dl2_reg  <= dl2_next;
            ep1_reg  <= ep1_next;
            ep2_reg  <= ep2_next;
            t2_reg   <= t1_reg;

            n3_reg    <= n3_next;
            mx3_reg   <= mx3_next;
            mn3_reg   <= mn3_next;
            done3_reg <= done3_next;
            hit3_reg  <= hit3_next;
            t3_reg    <= t2_reg;

            dp4_reg   <= dp4_next;
            den4_reg  <= den4_next;
            mx4_reg   <= mx3_reg;
            mn4_reg   <= mn3_reg;
            done4_reg <= done3_reg;
            hit4_reg  <= hit3_reg;
            t4_reg    <= t3_reg;

            den5_reg  <= den5_next;
            dd5_reg   <= dd5_next;
            use5_reg  <= use5_next;
            mx5_reg   <= mx4_reg;
            mn5_reg   <= mn4_reg;
            done5_reg <= done4_reg;
            hit5_reg  <= hit4_reg;
            t5_reg    <= t4_reg;

            td6_reg   <= td6_next;
            bmx6_reg  <= bmx6_next;
            bmn6_reg  <= bmn6_next;
            ed6_reg   <= ed6_next;
            av6_reg   <= av6_next;
            dd6_reg   <= dd5_reg;
            use6_reg  <= use5_reg;
            done6_reg <= done5_reg;
            hit6_reg  <= hit5_reg;

            wv7_reg   <= wv7_next;
            thr7_reg  <= thr7_next;
            ok7_reg   <= ok7_next;
            av7_reg   <= av6_reg;
            done7_reg <= done6_reg;
            hit7_reg  <= hit6_reg;

            cp8_reg   <= cp8_next;
            thr8_reg  <= thr7_reg;
            ok8_reg   <= ok7_reg;
            done8_reg <= done7_reg;
            hit8_reg  <= hit7_reg;

            res9_reg  <= res9_next;
        end
    end

endmodule

[sv/tco_checker.sv]
// Port-level checks for the triangle versus unit-cube overlap core, with its bind.
module tco_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_overlaps
);

    // empty result register always takes a word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty result register");

    // held result stalls the input side
    a_stall_propagates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result is held");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_overlaps)))
        else $error("held result changed or dropped");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind triangle_cube_overlap_core tco_checker u_tco_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_overlaps (m_overlaps)
);

[sim/tb_top.sv]
// Self-checking testbench for the triangle versus unit-cube overlap core.
`timescale 1ns / 100ps

module tb_top;
    import tco_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [15:0] tri_word_t [9];
    typedef longint vert_t [3];
    typedef vert_t tri_t [3];

    localparam longint HALF = 2048;
    localparam longint ONE = 4096;
    localparam int HOLD_OFF_LEN = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_v0_x = '0, s_v0_y = '0, s_v0_z = '0;
    logic signed [15:0] s_v1_x = '0, s_v1_y = '0, s_v1_z = '0;
    logic signed [15:0] s_v2_x = '0, s_v2_y = '0, s_v2_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_overlaps;
    logic cfg_we = 1'b0;
    logic [EPS_BITS-1:0] cfg_wdata = '0;

    tri_word_t pending_tris[$];
    logic overlap_exp_q[$];
    logic [EPS_BITS-1:0] eps_shadow = EPS_RESET;
    logic word_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off_on = 1'b0;
    int hold_off_cnt = 0;
    int mismatches = 0;
    tri_word_t cur_word;

    triangle_cube_overlap_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_v0_x     (s_v0_x),
        .s_v0_y     (s_v0_y),
        .s_v0_z     (s_v0_z),
        .s_v1_x     (s_v1_x),
        .s_v1_y     (s_v1_y),
        .s_v1_z     (s_v1_z),
        .s_v2_x     (s_v2_x),
        .s_v2_y     (s_v2_y),
        .s_v2_z     (s_v2_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_overlaps (m_overlaps),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [5:0] face_code(vert_t p);
        logic [5:0] c;
        c = '0;
        for (int j = 0; j < 3; j++) begin
            if (p[j] > HALF) c[2*j] = 1'b1;
            if (p[j] < -HALF) c[2*j+1] = 1'b1;
        end
        return c;
    endfunction

    function automatic logic [11:0] bevel_code(vert_t p);
        logic [11:0] c;
        longint a, b;
        c = '0;
        for (int q = 0; q < 3; q++) begin
            for (int k = 0; k < 4; k++) begin
                a = k[1] ? -p[SEG_P[q]] : p[SEG_P[q]];
                b = k[0] ? -p[SEG_Q[q]] : p[SEG_Q[q]];
                if (a + b > ONE) c[q*4+k] = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] corner_code(vert_t p);
        logic [7:0] c;
        longint sum;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            sum = (k[2] ? -p[0] : p[0]) + (k[1] ? -p[1] : p[1]) + (k[0] ? -p[2] : p[2]);
            if (sum > 3 * HALF) c[k] = 1'b1;
        end
        return c;
    endfunction

    function automatic bit segment_hits_face(vert_t p, vert_t q, logic [31:0] diff);
        int a;
        longint plane, d;
        bit hit;
        wide_t lim, num;
        for (int f = 0; f < NUM_FACE; f++) begin
            a = f >> 1;
            plane = f[0] ? -HALF : HALF;
            d = q[a] - p[a];
            if (diff[f] && d != 0) begin
                hit = 1'b1;
                lim = wide_t'(HALF) * wide_t'(d < 0 ? -d : d);
                for (int j = 0; j < 3; j++) begin
                    if (j != a) begin
                        num = wide_t'(p[j]) * wide_t'(d)
                            + wide_t'(plane - p[a]) * wide_t'(q[j] - p[j]);
                        if (d < 0) num = -num;
                        if (num > lim || num < -lim) hit = 1'b0;
                    end
                end
                if (hit) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit point_in_tri(tri_t t, logic [2:0] neg, wide_t dd, wide_t den,
                                        wide_t thr);
        logic [5:0] all_m, m;
        longint mx, mn;
        wide_t pk;
        wide_t av[3], wv[3], cr[3];
        int i, j;
        all_m = 6'h3f;
        for (int k = 0; k < 3; k++) begin
            pk = neg[k] ? -dd : dd;
            mx = t[0][k];
            mn = t[0][k];
            for (int v = 1; v < 3; v++) begin
                if (t[v][k] > mx) mx = t[v][k];
                if (t[v][k] < mn) mn = t[v][k];
            end
            if (pk > wide_t'(mx) * den) return 1'b0;
            if (pk < wide_t'(mn) * den) return 1'b0;
        end
        for (int e = 0; e < 3; e++) begin
            i = EDGE_I[e];
            j = EDGE_J[e];
            m = '0;
            for (int k = 0; k < 3; k++) begin
                pk = neg[k] ? -dd : dd;
                av[k] = wide_t'(t[i][k] - t[j][k]);
                wv[k] = wide_t'(t[i][k]) * den - pk;
            end
            cr[0] = av[1] * wv[2] - av[2] * wv[1];
            cr[1] = av[2] * wv[0] - av[0] * wv[2];
            cr[2] = av[0] * wv[1] - av[1] * wv[0];
            for (int k = 0; k < 3; k++) begin
                if (cr[k] < thr) m[2-k] = 1'b1;
                if (cr[k] > -thr) m[5-k] = 1'b1;
            end
            all_m &= m;
        end
        return all_m != 0;
    endfunction

    function automatic logic tri_overlaps_cube(tri_word_t w, logic [EPS_BITS-1:0] eps);
        tri_t t;
        logic [31:0] c[3];
        wide_t a12[3], a13[3], n[3];
        wide_t d, es, den, dd, thr, den_abs, dd_abs;
        logic [5:0] f;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                t[i][k] = longint'(w[3*i+k]);
        for (int i = 0; i < 3; i++) begin
            f = face_code(t[i]);
            if (f == 0) return 1'b1;
            c[i] = {corner_code(t[i]), 4'b0, bevel_code(t[i]), 2'b0, f};
        end
        if ((c[0] & c[1] & c[2]) != 0) return 1'b0;
        if ((c[0] & c[1]) == 0 && segment_hits_face(t[0], t[1], c[0] | c[1])) return 1'b1;
        if ((c[0] & c[2]) == 0 && segment_hits_face(t[0], t[2], c[0] | c[2])) return 1'b1;
        if ((c[1] & c[2]) == 0 && segment_hits_face(t[1], t[2], c[1] | c[2])) return 1'b1;
        for (int k = 0; k < 3; k++) begin
            a12[k] = wide_t'(t[0][k] - t[1][k]);
            a13[k] = wide_t'(t[0][k] - t[2][k]);
        end
        n[0] = a12[1] * a13[2] - a12[2] * a13[1];
        n[1] = a12[2] * a13[0] - a12[0] * a13[2];
        n[2] = a12[0] * a13[1] - a12[1] * a13[0];
        d = n[0] * wide_t'(t[0][0]) + n[1] * wide_t'(t[0][1]) + n[2] * wide_t'(t[0][2]);
        es = wide_t'(longint'(eps) * ONE);
        for (int g = 0; g < NUM_DIAG; g++) begin
            den = n[0];
            den = DIAG_NEG[g][1] ? den - n[1] : den + n[1];
            den = DIAG_NEG[g][2] ? den - n[2] : den + n[2];
            dd = d;
            den_abs = den < 0 ? -den : den;
            if (den_abs > es && den != 0) begin
                if (den < 0) begin
                    den = -den;
                    dd = -dd;
                end
                dd_abs = dd < 0 ? -dd : dd;
                if (!(dd_abs + dd_abs > wide_t'(ONE) * den)) begin
                    thr = es * den;
                    if (point_in_tri(t, DIAG_NEG[g], dd, den, thr)) return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // input side: accept, predict
    always @(posedge aclk) begin
        word_taken <= s_valid && s_ready;
        if (s_valid && s_ready)
            overlap_exp_q.insert(overlap_exp_q.size(), tri_overlaps_cube(cur_word, eps_shadow));
    end

    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !word_taken)) begin
            if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_word <= pending_tris[0];
                {s_v0_x, s_v0_y, s_v0_z} <= {pending_tris[0][0], pending_tris[0][1],
                                             pending_tris[0][2]};
                {s_v1_x, s_v1_y, s_v1_z} <= {pending_tris[0][3], pending_tris[0][4],
                                             pending_tris[0][5]};
                {s_v2_x, s_v2_y, s_v2_z} <= {pending_tris[0][6], pending_tris[0][7],
                                             pending_tris[0][8]};
                void'(pending_tris.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: stall and check
    always @(negedge aclk) begin
        if (hold_off_on && hold_off_cnt < HOLD_OFF_LEN) begin
            hold_off_cnt <= hold_off_cnt + 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (overlap_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: overlaps=%0b", m_overlaps);
            end else begin
                if (m_overlaps !== overlap_exp_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("overlaps mismatch: expected %0b, got %0b",
                                 overlap_exp_q[0], m_overlaps);
                end
                void'(overlap_exp_q.pop_front());
            end
        end
    end

    task automatic add_tri(int a, int b, int c, int d, int e, int f, int g, int h, int i);
        tri_word_t w;
        w = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h), 16'(i)};
        pending_tris.insert(pending_tris.size(), w);
    endtask

    function automatic int rnd_coord(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic add_random_tris(int count);
        tri_word_t w;
        int kind, cx, cy, cz;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(3);
            cx = rnd_coord(3500);
            cy = rnd_coord(3500);
            cz = rnd_coord(3500);
            for (int v = 0; v < 3; v++) begin
                case (kind)
                    0: begin
                        for (int k = 0; k < 3; k++) w[3*v+k] = 16'($urandom);
                    end
                    1: begin
                        for (int k = 0; k < 3; k++) w[3*v+k] = 16'(rnd_coord(6000));
                    end
                    default: begin
                        w[3*v]   = 16'(cx + rnd_coord(1800));
                        w[3*v+1] = 16'(cy + rnd_coord(1800));
                        w[3*v+2] = 16'(cz + rnd_coord(1800));
                    end
                endcase
            end
            pending_tris.insert(pending_tris.size(), w);
        end
    endtask

    task automatic write_eps(logic [EPS_BITS-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        eps_shadow = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (pending_tris.size() > 0 || s_valid || overlap_exp_q.size() > 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: extremes, vertex inside, boundary, bevels, edge and face crossings
        add_tri(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_tri(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
        add_tri(0, 0, 0, 9000, 9000, 9000, -9000, 9000, 0);
        add_tri(2048, 2048, 2048, 9000, 0, 0, 0, 9000, 0);
        add_tri(2049, 2049, 2049, 9000, 0, 0, 0, 9000, 0);
        add_tri(-2048, 0, 0, -9000, 0, 0, -9000, 100, 0);
        add_tri(3000, 3000, 0, 3000, 0, 3000, 0, 3000, 3000);
        add_tri(2100, 2100, 2100, 5000, 2100, 2100, 2100, 5000, 2100);
        add_tri(-6000, 0, 0, 6000, 0, 0, 6000, 100, 100);
        add_tri(-6000, 3000, 0, 6000, 3000, 0, 0, 3000, 6000);
        add_tri(-6000, -6000, 0, 6000, -6000, 0, 0, 6000, 0);
        add_tri(-6000, -6000, 1000, 6000, -6000, 1000, 0, 6000, 1000);
        add_tri(-6000, 0, 0, 6000, 0, 0, 12000, 0, 0);
        add_tri(-5000, 5000, 0, 5000, -5000, 0, 5000, -5000, 0);
        add_tri(4000, 0, 3000, 0, 4000, 3000, 4000, 4000, -3000);
        add_tri(-3000, 2500, -1000, 3000, 2500, -1000, 0, 2500, 2600);
        add_tri(2500, -2500, 2500, -2500, 2500, -2500, 2500, 2500, -2500);
        drain();

        write_eps(8'd0);
        add_tri(-6000, -6000, 0, 6000, -6000, 0, 0, 6000, 0);
        add_tri(-5000, 5000, 10, 5000, -5000, 10, 5000, -5000, 10);
        add_random_tris(100);
        drain();

        send_idle_pct = 59;
        write_eps(8'd255);
        add_tri(-6000, -6000, 0, 6000, -6000, 0, 0, 6000, 0);
        add_random_tris(150);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 59;
        write_eps(8'($urandom_range(2, 254)));
        add_random_tris(150);
        drain();

        send_idle_pct = 21;
        recv_stall_pct = 21;
        write_eps(8'($urandom_range(0, 255)));
        add_random_tris(150);
        drain();

        // long receiver hold-off while words keep arriving
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_eps(8'd1);
        hold_off_on = 1'b1;
        add_random_tris(100);
        drain();

        write_eps(8'($urandom_range(0, 255)));
        add_random_tris(150);
        drain();

        if (mismatches == 0 && overlap_exp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
